### rtl/fbfl_pkg.sv
// shared types and constants for the fixed block free list
`timescale 1ns / 1ps
`default_nettype none

package fbfl_pkg;

  localparam int IdxW    = 10;
  localparam int CntW    = 11;
  localparam int IdxSpan = 1024;

  localparam logic [1:0] CMD_GET  = 2'd0;
  localparam logic [1:0] CMD_PUT  = 2'd1;
  localparam logic [1:0] CMD_INIT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
  } link_t;

  typedef struct packed {
    logic clr;
    logic step;
  } walk_ctl_t;

endpackage

`default_nettype wire

### rtl/fbfl_link_ram.sv
// link store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module fbfl_link_ram #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrW-1:0]     waddr_i,
  input  wire fbfl_pkg::link_t      wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AddrW-1:0]     raddr_i,
  output fbfl_pkg::link_t           rdata_o
);
  import fbfl_pkg::*;

  link_t mem_q [Depth];
  link_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/fbfl_walker.sv
// init walker: node counter with shared increment and end compare
`timescale 1ns / 1ps
`default_nettype none

module fbfl_walker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fbfl_pkg::walk_ctl_t        ctl_i,
  input  wire logic [fbfl_pkg::CntW-1:0]  cnt_i,
  output logic [fbfl_pkg::IdxW-1:0]       idx_o,
  output logic [fbfl_pkg::CntW-1:0]       next_o,
  output logic                            last_o
);
  import fbfl_pkg::*;

  logic [IdxW-1:0] ctr_q, ctr_d;
  logic [CntW-1:0] next;

  assign next = {1'b0, ctr_q} + CntW'(1);

  always_comb begin
    ctr_d = ctr_q;
    if (ctl_i.clr) begin
      ctr_d = '0;
    end else if (ctl_i.step) begin
      ctr_d = next[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else begin
      ctr_q <= ctr_d;
    end
  end

  assign idx_o  = ctr_q;
  assign next_o = next;
  assign last_o = (next == cnt_i);

endmodule

`default_nettype wire

### rtl/fixed_block_free_list.sv
// top level: free list buffer pool allocator with sequencer and output register
// get: one link store read on the registered read port, then the new head is taken from the read data
// put, unused command and failed commands: one link store write at most
// init: the walker writes one link per cycle
// one command at a time; a result waits in the output register until taken
// reset: pool empty, node_count 1024, link store contents kept (no clearing pass)
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list #(
  parameter int POOL_DEPTH = 1024
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       node_count_we_i,
  input  wire logic [fbfl_pkg::CntW-1:0]  node_count_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 command_i,
  input  wire logic [fbfl_pkg::IdxW-1:0]  put_index_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [fbfl_pkg::IdxW-1:0]       granted_index_o,
  output logic [1:0]                      status_o
);
  import fbfl_pkg::*;

  localparam int MemDepth = (POOL_DEPTH < IdxSpan) ? POOL_DEPTH : IdxSpan;
  localparam int AddrW    = $clog2(MemDepth);
  localparam logic [CntW-1:0] MemDepthC = CntW'(MemDepth);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GET  = 2'd1;
  localparam logic [1:0] S_INIT = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] node_count_q;
  logic [CntW-1:0] eff_cnt;
  logic [IdxW-1:0] head_q, head_d;
  logic            head_valid_q, head_valid_d;
  logic [IdxW-1:0] res_gnt_q, res_gnt_d;
  logic [1:0]      res_st_q, res_st_d;
  logic            out_valid_q, out_valid_d;
  logic [IdxW-1:0] out_gnt_q;
  logic [1:0]      out_st_q;
  logic            out_free;
  logic            in_fire;

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr;
  link_t            mem_wdata, mem_rdata;

  walk_ctl_t        walk_ctl;
  logic [IdxW-1:0]  walk_idx;
  logic [CntW-1:0]  walk_next;
  logic             walk_last;

  assign eff_cnt  = (node_count_q > MemDepthC) ? MemDepthC : node_count_q;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  fbfl_link_ram #(
    .Depth (MemDepth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  fbfl_walker u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (walk_ctl),
    .cnt_i  (eff_cnt),
    .idx_o  (walk_idx),
    .next_o (walk_next),
    .last_o (walk_last)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    res_gnt_d    = res_gnt_q;
    res_st_d     = res_st_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    walk_ctl     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_gnt_d = '0;
          res_st_d  = ST_OK;
          state_d   = S_RESP;
          case (command_i)
            CMD_GET: begin
              if (head_valid_q) begin
                mem_re  = 1'b1;
                state_d = S_GET;
              end else begin
                res_st_d = ST_EMPTY;
              end
            end
            CMD_PUT: begin
              if ({1'b0, put_index_i} < eff_cnt) begin
                mem_we          = 1'b1;
                mem_waddr       = put_index_i[AddrW-1:0];
                mem_wdata.valid = head_valid_q;
                mem_wdata.idx   = head_q;
                head_d          = put_index_i;
                head_valid_d    = 1'b1;
              end else begin
                res_st_d = ST_RANGE;
              end
            end
            CMD_INIT: begin
              if (eff_cnt != '0) begin
                walk_ctl.clr = 1'b1;
                state_d      = S_INIT;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_GET: begin
        res_gnt_d    = head_q;
        head_d       = mem_rdata.idx;
        head_valid_d = mem_rdata.valid;
        state_d      = S_RESP;
      end
      S_INIT: begin
        mem_we        = 1'b1;
        mem_waddr     = walk_idx[AddrW-1:0];
        walk_ctl.step = 1'b1;
        if (walk_last) begin
          mem_wdata    = '0;
          head_d       = '0;
          head_valid_d = 1'b1;
          state_d      = S_RESP;
        end else begin
          mem_wdata.valid = 1'b1;
          mem_wdata.idx   = walk_next[IdxW-1:0];
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == S_RESP && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= CntW'(IdxSpan);
      head_q       <= '0;
      head_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      out_valid_q  <= out_valid_d;
      if (node_count_we_i) begin
        node_count_q <= node_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_gnt_q <= res_gnt_d;
    res_st_q  <= res_st_d;
    if (state_q == S_RESP && out_free) begin
      out_gnt_q <= res_gnt_q;
      out_st_q  <= res_st_q;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign granted_index_o = out_gnt_q;
  assign status_o        = out_st_q;

endmodule

`default_nettype wire

### rtl/fbfl_checker.sv
// port-level checks for the free list allocator and their binding
`timescale 1ns / 1ps
`default_nettype none

module fbfl_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [fbfl_pkg::IdxW-1:0]  granted_index_o,
  input wire logic [1:0]                 status_o
);
  import fbfl_pkg::*;

  // one command in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("transfer in while busy");

  // a failed command carries index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_index_o == '0)
    else $error("index on failed command");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(granted_index_o) && $stable(status_o))
    else $error("stalled result changed");

  // no result before a command has been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o || $past(!in_ready_o))
    else $error("result without command");

endmodule

bind fixed_block_free_list fbfl_checker u_fbfl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .granted_index_o (granted_index_o),
  .status_o        (status_o)
);

`default_nettype wire

### bench/fixed_block_free_list_test.sv
// self-checking testbench for the fixed block free list allocator
`timescale 1ns / 1ps

module fixed_block_free_list_test;
  import fbfl_pkg::*;

  localparam int PoolDepth = 1024;
  localparam logic [1:0] CmdNop = 2'd3;
  localparam int HoldCycles = 400;
  localparam int StallLimit = 20000;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [1:0]      st;
  } grant_t;

  class free_list_tracker;
    logic [CntW-1:0] link_mem [PoolDepth];
    logic [IdxW-1:0] head;
    bit              head_ok;
    logic [CntW-1:0] count_reg;
    grant_t          results_due [$];
    logic [IdxW-1:0] nodes_out [$];
    int              mismatches;

    function void clear();
      count_reg = CntW'(1024);
      head = '0;
      head_ok = 1'b0;
      mismatches = 0;
      foreach (link_mem[i]) link_mem[i] = '0;
    endfunction

    function int live_count();
      int c;
      c = count_reg;
      if (c > PoolDepth) c = PoolDepth;
      if (c > IdxSpan) c = IdxSpan;
      return c;
    endfunction

    // work out the result of one accepted command and update the list
    function void note(logic [1:0] cmd, logic [IdxW-1:0] idx);
      grant_t r;
      int cnt;
      int k;
      r = '0;
      cnt = live_count();
      case (cmd)
        CMD_GET: begin
          if (head_ok) begin
            r.idx = head;
            nodes_out.push_back(head);
            {head_ok, head} = link_mem[head];
          end else begin
            r.st = ST_EMPTY;
          end
        end
        CMD_PUT: begin
          if (idx < cnt) begin
            link_mem[idx] = {head_ok, head};
            head = idx;
            head_ok = 1'b1;
            for (k = 0; k < nodes_out.size(); k++) begin
              if (nodes_out[k] == idx) begin
                nodes_out.delete(k);
                break;
              end
            end
          end else begin
            r.st = ST_RANGE;
          end
        end
        CMD_INIT: begin
          if (cnt != 0) begin
            for (k = 0; k < cnt - 1; k++) link_mem[k] = {1'b1, IdxW'(k + 1)};
            link_mem[cnt - 1] = '0;
            head = '0;
            head_ok = 1'b1;
            nodes_out.delete();
          end
        end
        default: ;
      endcase
      results_due.push_back(r);
    endfunction

    function void check(logic [IdxW-1:0] idx, logic [1:0] st);
      grant_t e;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result: granted %0d status %0d", idx, st);
        return;
      end
      e = results_due.pop_front();
      if (idx !== e.idx || st !== e.st) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("result error: granted %0d status %0d, expected granted %0d status %0d",
                   idx, st, e.idx, e.st);
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            node_count_we_i;
  logic [CntW-1:0] node_count_i;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [1:0]      command_i;
  logic [IdxW-1:0] put_index_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [IdxW-1:0] granted_index_o;
  logic [1:0]      status_o;

  free_list_tracker sb;
  bit calm;
  bit hold_req;
  bit hold_done;
  int quiet_cycles;

  fixed_block_free_list #(
    .POOL_DEPTH(PoolDepth)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .node_count_we_i(node_count_we_i),
    .node_count_i(node_count_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .command_i(command_i),
    .put_index_i(put_index_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .granted_index_o(granted_index_o),
    .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one command transfer, then a random gap on the sender side
  task automatic send_item(logic [1:0] cmd, logic [IdxW-1:0] idx);
    int g;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    put_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note(cmd, idx);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_node_count(logic [CntW-1:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    node_count_we_i <= 1'b1;
    node_count_i <= v;
    @(posedge clk_i);
    node_count_we_i <= 1'b0;
    sb.count_reg = v;
  endtask

  // mostly well-formed get/put traffic, with some noise
  task automatic random_item();
    int r;
    int cnt;
    int k;
    logic [IdxW-1:0] idx;
    r = $urandom_range(0, 99);
    cnt = sb.live_count();
    idx = IdxW'($urandom);
    if (r < 3) begin
      send_item(CMD_INIT, idx);
    end else if (r < 7) begin
      send_item(CmdNop, idx);
    end else if (r < 12) begin
      send_item(CMD_PUT, idx);
    end else if (r < 20 && cnt > 0) begin
      send_item(CMD_PUT, IdxW'($urandom_range(0, cnt - 1)));
    end else if (r < 55 && sb.nodes_out.size() != 0) begin
      k = $urandom_range(0, sb.nodes_out.size() - 1);
      send_item(CMD_PUT, sb.nodes_out[k]);
    end else begin
      send_item(CMD_GET, idx);
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int g;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check(granted_index_o, status_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("fixed_block_free_list: mismatch");
      $finish;
    end
  end

  initial begin
    int phase_count [10];
    int p;
    int n;
    phase_count = '{8, 1024, 1, 2, 0, 64, 2047, 5, 17, 300};
    sb = new();
    sb.clear();
    calm = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    node_count_we_i = 1'b0;
    node_count_i = '0;
    in_valid_i = 1'b0;
    command_i = CMD_GET;
    put_index_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pool after reset, put before init, full-size init
    send_item(CMD_GET, 10'd0);
    send_item(CMD_PUT, 10'd5);
    send_item(CMD_GET, 10'd0);
    send_item(CMD_GET, 10'd1023);
    send_item(CmdNop, 10'd1023);
    send_item(CMD_INIT, 10'd0);
    send_item(CMD_GET, 10'd0);
    send_item(CMD_GET, 10'd0);
    send_item(CMD_PUT, 10'd1023);
    send_item(CMD_GET, 10'd0);
    // zero count: init leaves the list alone, every put out of range
    set_node_count(CntW'(0));
    send_item(CMD_INIT, 10'd0);
    send_item(CMD_PUT, 10'd0);
    send_item(CMD_GET, 10'd0);
    // single node pool
    set_node_count(CntW'(1));
    send_item(CMD_PUT, 10'd1);
    send_item(CMD_INIT, 10'd0);
    send_item(CMD_GET, 10'd0);
    send_item(CMD_GET, 10'd0);
    send_item(CMD_PUT, 10'd0);
    // count above the index span saturates
    set_node_count(CntW'(2047));
    send_item(CMD_PUT, 10'd1023);
    send_item(CMD_GET, 10'd0);

    for (p = 0; p < 10; p++) begin
      set_node_count(CntW'(phase_count[p]));
      calm = (p == 3 || p == 7);
      send_item(CMD_INIT, IdxW'($urandom));
      for (n = 0; n < 82; n++) begin
        if (p == 0 && n == 40) hold_req = 1'b1;
        random_item();
      end
    end

    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("fixed_block_free_list: match");
    end else begin
      $display("fixed_block_free_list: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/fbfl_pkg.sv
rtl/fbfl_link_ram.sv
rtl/fbfl_walker.sv
rtl/fixed_block_free_list.sv
rtl/fbfl_checker.sv
bench/fixed_block_free_list_test.sv
